/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL engine; empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/kdse_pkg.sv */
// Shared constants and types of the key dictionary search engine.
package kdse_pkg;

  localparam int DEPTH_DEF = 1024;

  // Field widths fixed by the interface.
  localparam int KEY_W   = 32;
  localparam int KSTOR_W = 31;
  localparam int POS_W   = 10;
  localparam int OPS_W   = 11;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 11;

  typedef logic [STAT_W-1:0] status_t;
  typedef logic [1:0]        method_t;
  typedef logic [1:0]        reg_idx_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_ERR  = 2'd2;

  localparam method_t SM_BINARY    = 2'd0;
  localparam method_t SM_LINEAR    = 2'd1;
  localparam method_t SM_TRANSPOSE = 2'd2;

  localparam reg_idx_t REG_TABLE_LIMIT   = 2'd0;
  localparam reg_idx_t REG_SORTED_MODE   = 2'd1;
  localparam reg_idx_t REG_SEARCH_METHOD = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [CFG_W-1:0] LIMIT_RST  = 11'd1024;
  localparam logic             SORTED_RST = 1'b1;
  localparam method_t          METHOD_RST = SM_BINARY;

endpackage

/* rtl/core/key_dictionary_search_engine.sv */
// Key table engine: sorted or unsorted insert, binary or linear search.
//
//   Channel   Direction  Payload (lowest bit first)
//   in_*      slave      tuser: req_type; tdata: key
//   out_*     master     tuser: status; tdata: position, op_count, zero pad
//   cfg_*     write      cfg_addr selects table_limit, sorted_mode, search_method
//
// Per word: errors and unsorted inserts go straight to the output queue. A
// sorted insert shifts one entry per cycle through the table memory,
// which reads one entry and writes another in the same cycle. Linear search
// makes one compare per memory read; a transposing hit adds the S_SWAP state
// for the second write. Binary search takes a read and a compare state per probe.
// Reset is synchronous and active low; it empties the table by clearing the entry count.
// A finished result waits in the output register, and a new word is taken
// while it waits; the engine stalls only when a second result is ready.
`include "assert_macros.svh"

module key_dictionary_search_engine
  import kdse_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input words.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [KEY_W-1:0]    in_tdata,   // [31:0] key
  input  logic                in_tuser,   // [0] req_type
  // Result words.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // [9:0] position, [20:10] op_count, [23:21] zero
  output logic [STAT_W-1:0]   out_tuser,  // [1:0] status
  // Configuration writes.
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LIN, S_SWAP, S_BIN_RD, S_BIN_CMP, S_INS, S_INS_PUT, S_OUTQ
  } state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     cfg_limit_r;
  logic                 cfg_sorted_r;
  method_t              cfg_method_r;
  logic [CW-1:0]        count_r;
  logic [KSTOR_W-1:0]   key_r;
  logic [KSTOR_W-1:0]   prev_r;
  logic [AW-1:0]        idx_r;
  logic [AW-1:0]        slot_r;
  logic [AW-1:0]        mid_r;
  logic [CW-1:0]        lo_r;
  logic [CW-1:0]        hie_r;
  logic [OPS_W-1:0]     ops_r;
  status_t              res_status_r;
  logic [POS_W-1:0]     res_pos_r;
  logic [OPS_W-1:0]     res_ops_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [OPS_W-1:0]     out_ops_r;

  // Key table memory: one read port with registered data, one write port.
  logic [KSTOR_W-1:0]   key_table_r [DEPTH];
  logic [KSTOR_W-1:0]   rdata_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KSTOR_W-1:0]   wr_data;

  logic                 in_accept;
  logic                 out_free;
  logic                 key_neg;
  logic                 tbl_full;
  logic                 tbl_empty;
  logic                 lin_match;
  logic                 lin_more;
  logic                 ins_greater;
  logic [SW-1:0]        mid_sum;
  logic [AW-1:0]        mid;
  logic                 bin_less;
  logic [CW-1:0]        lo_new;
  logic [CW-1:0]        hie_new;
  logic [31:0]          idx_ext;
  logic [31:0]          idx_inc;
  logic [31:0]          idx_dec;
  logic [31:0]          slot_ext;
  logic [31:0]          mid_ext;
  logic [31:0]          count_ext;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  assign key_neg   = in_tdata[KEY_W-1];
  assign tbl_full  = (32'(count_r) >= 32'(cfg_limit_r)) || (32'(count_r) >= 32'(DEPTH));
  assign tbl_empty = (count_r == '0);

  assign idx_ext   = 32'(idx_r);
  assign idx_inc   = idx_ext + 32'd1;
  assign idx_dec   = idx_ext - 32'd1;
  assign slot_ext  = 32'(slot_r);
  assign mid_ext   = 32'(mid_r);
  assign count_ext = 32'(count_r);

  assign lin_match   = (rdata_r == key_r);
  assign lin_more    = (idx_inc < count_ext);
  assign ins_greater = (rdata_r > key_r);

  // Probe index: floor((lo + hi) / 2) with hi = hie - 1, as hie is kept as an exclusive bound.
  assign mid_sum = SW'(lo_r) + SW'(hie_r) - SW'(1);
  assign mid     = AW'(mid_sum >> 1);

  assign bin_less = (rdata_r < key_r);
  assign lo_new   = bin_less ? CW'(mid_ext + 32'd1) : lo_r;
  assign hie_new  = bin_less ? hie_r : CW'(mid_ext);

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && !key_neg) begin
          if (in_tuser == REQ_INSERT) begin
            if (!tbl_full) begin
              if (!cfg_sorted_r || tbl_empty) begin
                wr_en   = 1'b1;
                wr_addr = AW'(count_r);
                wr_data = in_tdata[KSTOR_W-1:0];
              end else begin
                rd_en   = 1'b1;
                rd_addr = AW'(count_ext - 32'd1);
              end
            end
          end else if (!tbl_empty && cfg_method_r != SM_BINARY) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      S_LIN: begin
        if (lin_match) begin
          if (cfg_method_r == SM_TRANSPOSE && idx_r != '0) begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_dec);
            wr_data = key_r;
          end
        end else if (lin_more) begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_inc);
        end
      end
      S_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = prev_r;
      end
      S_BIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = mid;
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = slot_r;
        if (ins_greater) begin
          wr_data = rdata_r;
          if (slot_ext != 32'd1) begin
            rd_en   = 1'b1;
            rd_addr = AW'(slot_ext - 32'd2);
          end
        end else begin
          wr_data = key_r;
        end
      end
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = slot_r;
        wr_data = key_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_table_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= key_table_r[rd_addr];
    end
  end

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_limit_r  <= LIMIT_RST;
      cfg_sorted_r <= SORTED_RST;
      cfg_method_r <= METHOD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_TABLE_LIMIT:   cfg_limit_r  <= cfg_wdata;
        REG_SORTED_MODE:   cfg_sorted_r <= cfg_wdata[0];
        REG_SEARCH_METHOD: cfg_method_r <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_OUTQ the output register is reloaded below whenever it frees up.
      if (out_tready && state_r != S_OUTQ) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            key_r     <= in_tdata[KSTOR_W-1:0];
            ops_r     <= '0;
            res_ops_r <= '0;
            if (key_neg) begin
              res_status_r <= ST_ERR;
              res_pos_r    <= '0;
              state_r      <= S_OUTQ;
            end else if (in_tuser == REQ_INSERT) begin
              if (tbl_full) begin
                res_status_r <= ST_ERR;
                res_pos_r    <= '0;
                state_r      <= S_OUTQ;
              end else begin
                count_r <= CW'(count_ext + 32'd1);
                if (!cfg_sorted_r || tbl_empty) begin
                  res_status_r <= ST_OK;
                  res_pos_r    <= POS_W'(count_ext);
                  state_r      <= S_OUTQ;
                end else begin
                  slot_r  <= AW'(count_r);
                  state_r <= S_INS;
                end
              end
            end else if (tbl_empty) begin
              res_status_r <= ST_ERR;
              res_pos_r    <= '0;
              state_r      <= S_OUTQ;
            end else if (cfg_method_r == SM_BINARY) begin
              res_pos_r <= '0;
              lo_r      <= '0;
              hie_r     <= count_r;
              state_r   <= S_BIN_RD;
            end else begin
              res_pos_r <= '0;
              idx_r     <= '0;
              state_r   <= S_LIN;
            end
          end
        end
        S_LIN: begin
          if (lin_match) begin
            res_status_r <= ST_OK;
            res_ops_r    <= OPS_W'(idx_inc);
            if (cfg_method_r == SM_TRANSPOSE && idx_r != '0) begin
              res_pos_r <= POS_W'(idx_dec);
              state_r   <= S_SWAP;
            end else begin
              res_pos_r <= POS_W'(idx_ext);
              state_r   <= S_OUTQ;
            end
          end else begin
            prev_r <= rdata_r;
            if (lin_more) begin
              idx_r <= AW'(idx_inc);
            end else begin
              res_status_r <= ST_MISS;
              state_r      <= S_OUTQ;
            end
          end
        end
        S_SWAP: begin
          state_r <= S_OUTQ;
        end
        S_BIN_RD: begin
          mid_r   <= mid;
          state_r <= S_BIN_CMP;
        end
        S_BIN_CMP: begin
          ops_r <= ops_r + 1'b1;
          if (rdata_r == key_r) begin
            res_status_r <= ST_OK;
            res_pos_r    <= POS_W'(mid_ext);
            res_ops_r    <= ops_r + 1'b1;
            state_r      <= S_OUTQ;
          end else begin
            lo_r  <= lo_new;
            hie_r <= hie_new;
            if (lo_new >= hie_new) begin
              res_status_r <= ST_MISS;
              state_r      <= S_OUTQ;
            end else begin
              state_r <= S_BIN_RD;
            end
          end
        end
        S_INS: begin
          // Shift a larger key up one slot, or drop the new key into the gap.
          if (ins_greater) begin
            ops_r  <= ops_r + 1'b1;
            slot_r <= AW'(slot_ext - 32'd1);
            if (slot_ext == 32'd1) begin
              state_r <= S_INS_PUT;
            end
          end else begin
            res_status_r <= ST_OK;
            res_pos_r    <= POS_W'(slot_ext);
            res_ops_r    <= ops_r + 1'b1;
            state_r      <= S_OUTQ;
          end
        end
        S_INS_PUT: begin
          res_status_r <= ST_OK;
          res_pos_r    <= '0;
          res_ops_r    <= ops_r;
          state_r      <= S_OUTQ;
        end
        S_OUTQ: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_pos_r    <= res_pos_r;
            out_ops_r    <= res_ops_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_ops_r, out_pos_r};

  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, 32'(count_r) <= 32'(DEPTH))
  `ASSERT_IMPLIES(a_miss_zero_ops, clk, rst_n, out_valid_r && out_status_r != ST_OK,
    out_ops_r == '0 && out_pos_r == '0)
  `ASSERT_IMPLIES(a_bin_range, clk, rst_n, state_r == S_BIN_RD, lo_r < hie_r)
  `ASSERT_IMPLIES(a_ins_slot, clk, rst_n, state_r == S_INS, slot_r != '0)
  `ASSERT_NEXT(a_swap_done, clk, rst_n, state_r == S_SWAP, state_r == S_OUTQ)

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the key dictionary search engine.
`timescale 1ns / 1ps

module testbench
  import kdse_pkg::*;
();

  localparam int TABLE_DEPTH = DEPTH_DEF;

  // Even if every word took the longest table walk, a correct run would end
  // well within this limit, so it only catches a hung handshake.
  localparam int CYCLE_LIMIT = 10_000_000;

  // Codes that the package leaves unnamed.
  localparam reg_idx_t REG_UNUSED = 2'd3;
  localparam method_t  SM_UNUSED  = 2'd3;

  // One expected result word, split into its fields.
  typedef struct {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [OPS_W-1:0] op_count;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [KEY_W-1:0]  in_tdata = '0;   // [31:0] key
  logic              in_tuser = 1'b0; // [0] req_type
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;       // [9:0] position, [20:10] op_count, [23:21] zero
  logic [STAT_W-1:0] out_tuser;       // [1:0] status
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // Shadow copy of the key table and the registers, updated as each word is
  // accepted so that expectations come out in acceptance order.
  logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  int unsigned      shadow_count = 0;
  logic [CFG_W-1:0] shadow_limit = LIMIT_RST;
  logic             shadow_sorted = SORTED_RST;
  method_t          shadow_method = METHOD_RST;

  lookup_result_t expected_results [$];
  int unsigned    error_count = 0;
  int unsigned    cycle_count = 0;

  // Random idling on both sides is switched off for one long stretch.
  logic gaps_on = 1'b1;
  // While nonzero the result side refuses words; counted down per cycle.
  int unsigned result_hold_cycles = 0;

  key_dictionary_search_engine #(.DEPTH(TABLE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever begin
      #4 clk = ~clk;
    end
  end

  // Watchdog: a run that never drains ends here.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Applies one request to the shadow table and returns the result that the
  // engine must produce for it. Inserts and transposing hits change the table.
  function automatic lookup_result_t apply_request(logic req, logic [KEY_W-1:0] key);
    lookup_result_t res;
    int unsigned    limit;
    int unsigned    slot;
    int unsigned    ops;
    int             lo;
    int             hi;
    int             mid;
    logic [KEY_W-1:0] swap;

    res.status   = ST_MISS;
    res.position = '0;
    res.op_count = '0;
    ops = 0;

    // A negative key is refused before anything else is looked at.
    if (key[KEY_W-1]) begin
      res.status = ST_ERR;
      return res;
    end

    if (req == REQ_INSERT) begin
      limit = (shadow_limit < TABLE_DEPTH) ? shadow_limit : TABLE_DEPTH;
      if (shadow_count >= limit) begin
        res.status = ST_ERR;
        return res;
      end
      slot = shadow_count;
      if (shadow_sorted) begin
        // Insertion step: larger keys move up one place, equal keys stay ahead.
        while (slot > 0 && shadow_keys[slot-1] > key) begin
          shadow_keys[slot] = shadow_keys[slot-1];
          ops++;
          slot--;
        end
        if (slot > 0) ops++;
      end
      shadow_keys[slot] = key;
      shadow_count++;
      res.status   = ST_OK;
      res.position = slot[POS_W-1:0];
      res.op_count = ops[OPS_W-1:0];
      return res;
    end

    if (shadow_count == 0) begin
      res.status = ST_ERR;
      return res;
    end

    case (shadow_method)
      SM_BINARY: begin
        // Runs the same way on an unsorted table and may miss there.
        lo = 0;
        hi = int'(shadow_count) - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          ops++;
          if (shadow_keys[mid] == key) begin
            res.status   = ST_OK;
            res.position = mid[POS_W-1:0];
            res.op_count = ops[OPS_W-1:0];
            return res;
          end
          if (shadow_keys[mid] < key) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      SM_TRANSPOSE: begin
        for (slot = 0; slot < shadow_count; slot++) begin
          ops++;
          if (shadow_keys[slot] == key) begin
            res.status   = ST_OK;
            res.op_count = ops[OPS_W-1:0];
            if (slot != 0) begin
              // A hit moves one place toward the front.
              swap = shadow_keys[slot-1];
              shadow_keys[slot-1] = shadow_keys[slot];
              shadow_keys[slot] = swap;
              slot--;
            end
            res.position = slot[POS_W-1:0];
            return res;
          end
        end
      end
      default: begin
        // Plain linear search; the unused method code lands here as well.
        for (slot = 0; slot < shadow_count; slot++) begin
          ops++;
          if (shadow_keys[slot] == key) begin
            res.status   = ST_OK;
            res.position = slot[POS_W-1:0];
            res.op_count = ops[OPS_W-1:0];
            return res;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Result side: checks every accepted word against the oldest expectation
  // and decides the next cycle's tready, including the long hold-off.
  initial begin
    lookup_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, actual status %0d tdata %h",
                   $time, out_tuser, out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_tuser));
          compare_field("position", 32'(want.position), 32'(out_tdata[9:0]));
          compare_field("op_count", 32'(want.op_count), 32'(out_tdata[20:10]));
          compare_field("pad", 0, 32'(out_tdata[23:21]));
        end
      end
      if (result_hold_cycles > 0) begin
        result_hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < 30);
      end
    end
  end

  // Offers one word, possibly after a few idle cycles, and returns at the edge
  // where it is taken. tvalid stays high so that a following word can go
  // straight out; whoever stops sending lowers it.
  task automatic send_request(input logic req, input logic [KEY_W-1:0] key);
    while (gaps_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(apply_request(req, key));
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register writes happen only with the engine idle.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_TABLE_LIMIT:   shadow_limit = value;
      REG_SORTED_MODE:   shadow_sorted = value[0];
      REG_SEARCH_METHOD: shadow_method = method_t'(value[1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly small keys so that duplicates and hits are common.
  function automatic logic [KEY_W-1:0] random_key();
    if ($urandom_range(99) < 65) return KEY_W'($urandom_range(255));
    return $urandom & 32'h7FFF_FFFF;
  endfunction

  // Searches hit a stored key most of the time.
  function automatic logic [KEY_W-1:0] search_key();
    if (shadow_count > 0 && $urandom_range(99) < 70)
      return shadow_keys[$urandom_range(shadow_count - 1)];
    return random_key();
  endfunction

  task automatic send_random_mix(input int unsigned count);
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) send_request(1'($urandom_range(1)), $urandom | 32'h8000_0000);
      else if (pick < 48) send_request(REQ_INSERT, random_key());
      else send_request(REQ_SEARCH, search_key());
    end
  endtask

  // Error paths: empty table, a zero limit, negative keys.
  task automatic test_error_cases();
    send_request(REQ_SEARCH, 32'd5);
    write_reg(REG_TABLE_LIMIT, 11'd0);
    send_request(REQ_INSERT, 32'd7);
    write_reg(REG_TABLE_LIMIT, 11'd1024);
    send_request(REQ_INSERT, 32'h8000_0000);
    send_request(REQ_SEARCH, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'hFFFF_FFFF);
  endtask

  // Sorted inserts with extreme and duplicate keys, then binary lookups.
  task automatic test_sorted_table();
    send_request(REQ_INSERT, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 32'd0);
    send_request(REQ_INSERT, 32'd100);
    send_request(REQ_INSERT, 32'd50);
    send_request(REQ_INSERT, 32'd100);
    send_request(REQ_INSERT, 32'd0);
    send_request(REQ_SEARCH, 32'd100);
    send_request(REQ_SEARCH, 32'h7FFF_FFFF);
    send_request(REQ_SEARCH, 32'd0);
    send_request(REQ_SEARCH, 32'd77);
  endtask

  // Linear search, the unused method code, and transposing hits including
  // one at the head of the table.
  task automatic test_search_methods();
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_LINEAR));
    send_request(REQ_SEARCH, 32'h7FFF_FFFF);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_UNUSED));
    send_request(REQ_SEARCH, 32'd50);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_TRANSPOSE));
    send_request(REQ_SEARCH, 32'd100);
    send_request(REQ_SEARCH, 32'd100);
    send_request(REQ_SEARCH, 32'd0);
    send_request(REQ_SEARCH, 32'd12345);
  endtask

  // Appends in unsorted mode, binary search on the unsorted table, and a
  // write to the unused register index, which must leave the mode alone.
  task automatic test_unsorted_append();
    write_reg(REG_SORTED_MODE, 11'd0);
    send_request(REQ_INSERT, 32'd25);
    send_request(REQ_INSERT, 32'd3);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_BINARY));
    send_request(REQ_SEARCH, 32'd25);
    send_request(REQ_SEARCH, 32'd3);
    write_reg(REG_UNUSED, 11'h7FF);
    send_request(REQ_INSERT, 32'd1);
  endtask

  // Random traffic under a series of register settings. The table only grows,
  // so the mix keeps it to a few hundred entries.
  task automatic test_random_traffic();
    write_reg(REG_TABLE_LIMIT, 11'd1024);
    write_reg(REG_SORTED_MODE, 11'd1);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_BINARY));
    send_random_mix(100);

    // One long stretch with no idling on either side.
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_LINEAR));
    gaps_on = 1'b0;
    send_random_mix(100);
    wait_for_results();
    gaps_on = 1'b1;

    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_TRANSPOSE));
    send_random_mix(100);

    // A tight limit makes inserts fail once a few more keys are in.
    write_reg(REG_TABLE_LIMIT, CFG_W'(shadow_count + 6));
    write_reg(REG_SORTED_MODE, 11'd0);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_UNUSED));
    send_random_mix(90);

    write_reg(REG_TABLE_LIMIT, 11'd1024);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_BINARY));
    send_random_mix(90);

    // Back to sorted inserts on a table that is no longer in order.
    write_reg(REG_SORTED_MODE, 11'd1);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_TRANSPOSE));
    send_random_mix(100);
  endtask

  // The result side holds off while words keep coming, so the engine fills
  // its output register and stalls the input; then the sender waits for
  // every result before going on.
  task automatic test_backpressure();
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_LINEAR));
    result_hold_cycles = 400;
    send_random_mix(10);
    wait_for_results();
    send_random_mix(10);
    wait_for_results();
  endtask

  // Fills the table to one below its full depth with cheap appends, then runs the
  // longest operations: a sorted insert that shifts every entry, searches
  // that walk the whole table, and an insert into the full table.
  task automatic test_full_table();
    write_reg(REG_TABLE_LIMIT, 11'd1024);
    write_reg(REG_SORTED_MODE, 11'd0);
    while (shadow_count < TABLE_DEPTH - 1)
      send_request(REQ_INSERT, KEY_W'($urandom_range(32'h7FFF_FFFF, 1)));
    write_reg(REG_SORTED_MODE, 11'd1);
    send_request(REQ_INSERT, 32'd0);
    send_request(REQ_INSERT, 32'd9);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_LINEAR));
    send_request(REQ_SEARCH, shadow_keys[TABLE_DEPTH-1]);
    send_request(REQ_SEARCH, 32'h8000_0001 ^ 32'h8000_0000);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_TRANSPOSE));
    send_request(REQ_SEARCH, shadow_keys[TABLE_DEPTH-1]);
    write_reg(REG_SEARCH_METHOD, CFG_W'(SM_BINARY));
    send_request(REQ_SEARCH, shadow_keys[0]);
    send_request(REQ_SEARCH, shadow_keys[TABLE_DEPTH/2]);
    // A limit below the entry count refuses further inserts too.
    write_reg(REG_TABLE_LIMIT, 11'd5);
    send_request(REQ_INSERT, 32'd11);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_error_cases();
    test_sorted_table();
    test_search_methods();
    test_unsorted_append();
    test_random_traffic();
    test_backpressure();
    test_full_table();

    // Let any stray result word show up before the verdict.
    wait_for_results();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/kdse_pkg.sv
rtl/core/key_dictionary_search_engine.sv
bench/testbench.sv
